// ----- design/dpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// shared types and constants of the point clustering block
// ----------------------------------------------------------------------------
package dpc_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_EPS_SQUARED    = 8'd0;
    localparam logic [7:0] CFG_MIN_NEIGHBOURS = 8'd1;

    localparam int EPS_W = 35;
    localparam int MIN_W = 7;
    localparam int OUT_IDX_W = 6;
    localparam logic [MIN_W-1:0] MIN_RESET = 7'd4;

    // live configuration handed to the clustering engine
    typedef struct packed {
        logic [EPS_W-1:0] eps_squared;
        logic [MIN_W-1:0] min_neighbours;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic                 no_cluster;
        logic                 all_done;
        logic                 cluster_end;
        logic [OUT_IDX_W-1:0] cluster_number;
        logic [OUT_IDX_W-1:0] point_index;
    } t_result;

endpackage

// ----- design/dpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_front
// accepts point words and marks whether each one fits in the store
// ----------------------------------------------------------------------------
module dpc_front #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int DW         = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [DW-1:0]           i_s_tdata,   // coord_x, coord_y, coord_z
    input  logic                    i_s_tlast,   // last_point
    output logic                    o_q_push,
    output logic [3*COORD_BITS+1:0] o_q_data,    // coords, last, store
    input  logic                    i_q_full
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);

    logic [CNTW-1:0] r_cnt;
    logic            w_store;

    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;
    assign w_store    = (r_cnt < CNTW'(MAX_POINTS));
    assign o_q_data   = {w_store, i_s_tlast, i_s_tdata[3*COORD_BITS-1:0]};

    // running fill count of the current point set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_q_push) begin
            if (i_s_tlast) begin
                r_cnt <= '0;
            end else if (w_store) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

// ----- design/dpc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module dpc_queue #(
    parameter int WIDTH = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [4];
    logic [1:0]       r_wp;
    logic [1:0]       r_rp;
    logic [2:0]       r_fill;

    assign o_full  = (r_fill == 3'd4);
    assign o_valid = (r_fill != 3'd0);
    assign o_data  = r_slot[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_fill <= r_fill + {2'b0, i_push} - {2'b0, i_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end

endmodule

// ----- design/dpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_back
// point store and clustering engine with its result register
// ----------------------------------------------------------------------------
module dpc_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dpc_pkg::t_cfg           i_cfg,
    input  logic                    i_q_valid,
    input  logic [3*COORD_BITS+1:0] i_q_data,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output dpc_pkg::t_result        o_result
);

    localparam int C    = COORD_BITS;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int SW   = 2 * C + 4;
    localparam int CW   = (SW > dpc_pkg::EPS_W) ? SW : dpc_pkg::EPS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_OUTER, S_QRD, S_QCAP, S_SCAN, S_EXPAND, S_EMIT, S_FINISH
    } t_state;

    t_state r_state;

    logic [3*C-1:0]        r_mem [MAX_POINTS];
    logic [3*C-1:0]        r_rd;
    logic [IW-1:0]         w_raddr;

    logic [CNTW-1:0]       r_cnt, r_i, r_j, r_ncnt;
    logic [IW-1:0]         r_qp;
    logic                  r_ret;
    logic [MAX_POINTS-1:0] r_vis, r_memb, r_fr, r_proc, r_clu, r_set;
    logic [C-1:0]          r_px, r_py, r_pz;
    logic [dpc_pkg::OUT_IDX_W-1:0] r_cnum;

    // distance pipeline
    logic                  r_v0, r_v1;
    logic [IW-1:0]         r_idx0, r_idx1;
    logic                  r_zero1;
    logic [2*C+1:0]        r_sqx, r_sqy, r_sqz;
    logic signed [C:0]     w_dx, w_dy, w_dz;
    logic signed [2*C+1:0] w_mx, w_my, w_mz;
    logic [SW-1:0]         w_sum;
    logic                  w_near;

    dpc_pkg::t_result      r_hold, r_out, w_new;
    logic                  r_hold_v, r_ovalid, w_out_free, w_load;
    logic [MAX_POINTS-1:0] w_pend, w_oh, w_ibit, w_hi;
    logic [IW-1:0]         w_q;
    logic                  w_core;
    logic [C-1:0]          w_qx, w_qy, w_qz;

    assign o_valid    = r_ovalid;
    assign o_result   = r_out;
    assign w_out_free = !r_ovalid || i_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;

    // output register takes a new word this cycle
    assign w_load = w_out_free && (((r_state == S_EMIT) && (r_j != r_cnt) &&
                                    r_clu[r_j[IW-1:0]] && r_hold_v) ||
                                   (r_state == S_FINISH));

    assign w_qx = i_q_data[C-1:0];
    assign w_qy = i_q_data[2*C-1:C];
    assign w_qz = i_q_data[3*C-1:2*C];

    assign w_raddr = (r_state == S_QRD) ? r_qp : r_j[IW-1:0];

    // point store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_data[3*C+1]) begin
            r_mem[r_cnt[IW-1:0]] <= {w_qz, w_qy, w_qx};
        end
        r_rd <= r_mem[w_raddr];
    end

    // differences and squares against the query point
    always_comb begin
        w_dx = $signed({r_rd[C-1], r_rd[C-1:0]}) - $signed({r_px[C-1], r_px});
        w_dy = $signed({r_rd[2*C-1], r_rd[2*C-1:C]}) - $signed({r_py[C-1], r_py});
        w_dz = $signed({r_rd[3*C-1], r_rd[3*C-1:2*C]}) - $signed({r_pz[C-1], r_pz});
        w_mx = w_dx * w_dx;
        w_my = w_dy * w_dy;
        w_mz = w_dz * w_dz;
        w_sum = SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
        w_near = !r_zero1 && (CW'(w_sum) < CW'(i_cfg.eps_squared));
    end

    // lowest pending frontier point and cluster helpers
    always_comb begin
        w_pend = r_fr & ~r_proc;
        w_oh   = w_pend & (~w_pend + 1'b1);
        w_q    = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (w_oh[k]) w_q = w_q | IW'(k);
        end
        w_ibit = MAX_POINTS'(1) << r_i[IW-1:0];
        w_hi   = r_clu >> r_j[IW-1:0];
        w_core = (dpc_pkg::MIN_W'(r_ncnt) >= i_cfg.min_neighbours);
        w_new.no_cluster     = 1'b0;
        w_new.all_done       = 1'b0;
        w_new.cluster_end    = ((w_hi >> 1) == '0);
        w_new.cluster_number = r_cnum;
        w_new.point_index    = dpc_pkg::OUT_IDX_W'(r_j[IW-1:0]);
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= (r_state == S_SCAN) && (r_j < r_cnt);
            r_v1 <= r_v0;
        end
        r_idx0  <= r_j[IW-1:0];
        r_idx1  <= r_idx0;
        r_zero1 <= (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
        r_sqx   <= $unsigned(w_mx);
        r_sqy   <= $unsigned(w_my);
        r_sqz   <= $unsigned(w_mz);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_ncnt   <= '0;
            r_qp     <= '0;
            r_ret    <= 1'b0;
            r_vis    <= '0;
            r_memb   <= '0;
            r_fr     <= '0;
            r_proc   <= '0;
            r_clu    <= '0;
            r_set    <= '0;
            r_cnum   <= '0;
            r_hold_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= w_load || (r_ovalid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_data[3*C+1]) r_cnt <= r_cnt + 1'b1;
                        if (i_q_data[3*C]) begin
                            r_i     <= '0;
                            r_state <= S_OUTER;
                        end
                    end
                end
                S_OUTER: begin
                    if (r_i == r_cnt) begin
                        r_state <= S_FINISH;
                    end else if (r_vis[r_i[IW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_vis   <= r_vis | w_ibit;
                        r_qp    <= r_i[IW-1:0];
                        r_ret   <= 1'b0;
                        r_state <= S_QRD;
                    end
                end
                S_QRD: begin
                    r_state <= S_QCAP;
                end
                S_QCAP: begin
                    r_px    <= r_rd[C-1:0];
                    r_py    <= r_rd[2*C-1:C];
                    r_pz    <= r_rd[3*C-1:2*C];
                    r_j     <= '0;
                    r_set   <= '0;
                    r_ncnt  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_j < r_cnt) r_j <= r_j + 1'b1;
                    if (r_v1 && w_near) begin
                        r_set  <= r_set | (MAX_POINTS'(1) << r_idx1);
                        r_ncnt <= r_ncnt + 1'b1;
                    end
                    if ((r_j == r_cnt) && !r_v0 && !r_v1) begin
                        if (!r_ret) begin
                            r_fr <= r_set;
                            if (w_core) begin
                                r_clu   <= w_ibit;
                                r_memb  <= r_memb | w_ibit;
                                r_proc  <= '0;
                                r_state <= S_EXPAND;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_OUTER;
                            end
                        end else begin
                            if (w_core) r_fr <= r_fr | r_set;
                            r_state <= S_EXPAND;
                        end
                    end
                end
                S_EXPAND: begin
                    if (w_pend == '0) begin
                        r_j     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_proc <= r_proc | w_oh;
                        if ((r_memb & w_oh) == '0) begin
                            r_memb <= r_memb | w_oh;
                            r_clu  <= r_clu | w_oh;
                        end
                        if ((r_vis & w_oh) == '0) begin
                            r_vis   <= r_vis | w_oh;
                            r_qp    <= w_q;
                            r_ret   <= 1'b1;
                            r_state <= S_QRD;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_j == r_cnt) begin
                        r_cnum  <= r_cnum + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_OUTER;
                    end else if (!r_clu[r_j[IW-1:0]]) begin
                        r_j <= r_j + 1'b1;
                    end else if (!r_hold_v || w_out_free) begin
                        if (r_hold_v) begin
                            r_out <= r_hold;
                        end
                        r_hold   <= w_new;
                        r_hold_v <= 1'b1;
                        r_j      <= r_j + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        if (r_hold_v) begin
                            r_out <= {r_hold.no_cluster, 1'b1, r_hold.cluster_end,
                                      r_hold.cluster_number, r_hold.point_index};
                        end else begin
                            r_out <= {1'b1, 1'b1, 1'b0,
                                      {(2 * dpc_pkg::OUT_IDX_W){1'b0}}};
                        end
                        r_hold_v <= 1'b0;
                        r_cnt    <= '0;
                        r_vis    <= '0;
                        r_memb   <= '0;
                        r_fr     <= '0;
                        r_cnum   <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/dbscan_point_clustering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbscan_point_clustering
// brute-force density clustering of a small 3d point set
// ----------------------------------------------------------------------------
// Points arrive on the slave stream, one word per point, tlast on the final
// point of a set. Each word is taken into a four-entry queue; the engine
// pops it while idle and writes it into a point memory if it fits. The word with
// tlast starts clustering: every neighbour query sweeps the stored points
// through the single memory read port and a distance pipeline, and each
// cluster found is emitted in a pass over the stored points.
// Results leave on the master stream, one word per cluster member; tlast
// marks the last member of a cluster, tuser bit 1 the empty result.
// The output register holds its word while tready is low and the engine
// waits behind it; the queue keeps accepting points meanwhile until full.
// Configuration writes go to their own channel, always ready; the user writes while idle, unenforced.
// Reset is synchronous and active low: queue, counters and bit sets clear,
// eps_squared returns to 0 and min_neighbours to 4.
// ----------------------------------------------------------------------------
module dbscan_point_clustering #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] i_s_tdata, // coord_x, coord_y, coord_z
    input  logic        i_s_tlast,                        // last_point
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // point_index, cluster_number, zero fill
    output logic        o_m_tlast,  // cluster_end
    output logic [1:0]  o_m_tuser,  // all_done, no_cluster
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [34:0] i_cfg_data
);

    localparam int DW = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int QW = 3 * COORD_BITS + 2;

    dpc_pkg::t_cfg    r_cfg;
    dpc_pkg::t_result w_res;
    logic             w_push, w_full, w_pop, w_qvalid;
    logic [QW-1:0]    w_qin, w_qout;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eps_squared    <= '0;
            r_cfg.min_neighbours <= dpc_pkg::MIN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dpc_pkg::CFG_EPS_SQUARED) begin
                r_cfg.eps_squared <= i_cfg_data;
            end else if (i_cfg_index == dpc_pkg::CFG_MIN_NEIGHBOURS) begin
                r_cfg.min_neighbours <= i_cfg_data[dpc_pkg::MIN_W-1:0];
            end
        end
    end

    dpc_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .DW         (DW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_q_push   (w_push),
        .o_q_data   (w_qin),
        .i_q_full   (w_full)
    );

    dpc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qout)
    );

    dpc_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_qvalid),
        .i_q_data  (w_qout),
        .o_q_pop   (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_result  (w_res)
    );

    assign o_m_tdata = {4'b0, w_res.cluster_number, w_res.point_index};
    assign o_m_tlast = w_res.cluster_end;
    assign o_m_tuser = {w_res.no_cluster, w_res.all_done};

endmodule

// ----- design/dpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_checker
// port-level checks of the clustering block, bound to the top level
// ----------------------------------------------------------------------------
module dpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [1:0]  o_m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // the empty result closes the set
    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0])
        else $error("empty result without all_done");

    // the empty result carries zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> (o_m_tdata == 16'd0) && !o_m_tlast)
        else $error("empty result with non-zero fields");

    // nothing leaves straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind dbscan_point_clustering dpc_checker u_dpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
